// ----- hdl/rewds_pkg.sv -----
// Shared types and constants of the radial exponentially weighted descriptor sum unit.
package rewds_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_EMIT   = 2'd2;

    localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;
    localparam logic [31:0] PC1       = 32'd744261118;
    localparam logic [31:0] PC2       = 32'd257941248;
    localparam logic [31:0] PC3       = 32'd59597083;
    localparam logic [31:0] PC4       = 32'd10327388;
    localparam logic [31:0] PC5       = 32'd1431680;
    localparam logic [31:0] ONE_Q30   = 32'd1073741824;

    typedef struct packed {
        logic               start;
        logic signed [15:0] descriptor;
        logic signed [15:0] alpha;
        logic signed [15:0] weight;
    } term_req_t;

    typedef struct packed {
        logic               done;
        logic signed [32:0] value;
    } term_rsp_t;

    function automatic logic [31:0] horner_coef(input logic [2:0] step);
        logic [31:0] c;
        case (step)
            3'd0:    c = PC4;
            3'd1:    c = PC3;
            3'd2:    c = PC2;
            3'd3:    c = PC1;
            default: c = ONE_Q30;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/radial_exp_weighted_descriptor_sum_unit.sv -----
// Top level of the radial exponentially weighted descriptor sum unit.
// A neighbour sample runs its NUM_TERMS terms in turn through one shared
// multiplier, with the Horner evaluation of 2^f making up most of the steps of
// each term. An end-of-atom request sends NUM_TERMS results, one a cycle while
// m_tready is high, and clears the sums. After reset a clearing pass zeroes the
// alpha and weight tables; s_tready stays low until it ends.
module radial_exp_weighted_descriptor_sum_unit
    import rewds_pkg::*;
#(
    parameter int NUM_TERMS   = 8,
    parameter int NUM_SPECIES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0], species[3:2], alpha_index[6:4], alpha_value[22:7],
    // weight_value[38:23], descriptor[54:39]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // term_index[2:0], sum_value[34:3]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    localparam int DEPTH = NUM_SPECIES * NUM_TERMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_START, S_WAIT, S_EMIT
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_reg;
    logic [IW-1:0]      cnt_reg;
    logic [1:0]         sp_reg;
    logic signed [15:0] d_reg;
    logic signed [31:0] sum_reg [NUM_TERMS];
    logic               m_tvalid_reg;
    logic [2:0]         m_index_reg;
    logic signed [31:0] m_sum_reg;
    logic               m_last_reg;

    logic [1:0]         in_op, in_sp;
    logic [2:0]         in_ai;
    logic               accept, wr_ok, sp_ok, cnt_last, out_free;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata, ram_rdata;
    term_req_t          treq;
    term_rsp_t          trsp;
    logic signed [33:0] acc_sum;
    logic signed [31:0] sum_next;

    assign in_op    = s_tdata[1:0];
    assign in_sp    = s_tdata[3:2];
    assign in_ai    = s_tdata[6:4];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sp_ok    = 32'(in_sp) < 32'(NUM_SPECIES);
    assign wr_ok    = sp_ok && (32'(in_ai) < 32'(NUM_TERMS));
    assign cnt_last = 32'(cnt_reg) == 32'(NUM_TERMS - 1);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && (in_op == OP_WRITE) && wr_ok;
            ram_waddr = AW'(32'(in_sp) * 32'(NUM_TERMS) + 32'(in_ai));
            ram_wdata = s_tdata[38:7];
        end
        ram_raddr = AW'(32'(sp_reg) * 32'(NUM_TERMS) + 32'(cnt_reg));
    end

    rewds_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        treq.start      = (state_reg == S_START);
        treq.descriptor = d_reg;
        treq.alpha      = signed'(ram_rdata[15:0]);
        treq.weight     = signed'(ram_rdata[31:16]);
    end

    rewds_term u_term (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (treq),
        .rsp     (trsp)
    );

    always_comb begin
        acc_sum = 34'(sum_reg[cnt_reg]) + 34'(trsp.value);
        if (acc_sum > 34'sh0_7FFF_FFFF) begin
            sum_next = 32'sh7FFF_FFFF;
        end else if (acc_sum < -34'sh0_8000_0000) begin
            sum_next = 32'sh8000_0000;
        end else begin
            sum_next = acc_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_TERMS; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            if (m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == 32'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        sp_reg  <= in_sp;
                        d_reg   <= signed'(s_tdata[54:39]);
                        cnt_reg <= '0;
                        if (in_op == OP_SAMPLE && sp_ok) begin
                            state_reg <= S_RD;
                        end else if (in_op == OP_EMIT) begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_RD:    state_reg <= S_START;
                S_START: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (trsp.done) begin
                        sum_reg[cnt_reg] <= sum_next;
                        cnt_reg          <= cnt_reg + IW'(1);
                        state_reg        <= cnt_last ? S_IDLE : S_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg     <= 1'b1;
                        m_index_reg      <= 3'(cnt_reg);
                        m_sum_reg        <= sum_reg[cnt_reg];
                        m_last_reg       <= cnt_last;
                        sum_reg[cnt_reg] <= '0;
                        cnt_reg          <= cnt_reg + IW'(1);
                        if (cnt_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_sum_reg, m_index_reg};
    assign m_tlast  = m_last_reg;
endmodule

// ----- hdl/rewds_ram.sv -----
// Generic single-port-write, registered-read RAM.
module rewds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/rewds_term.sv -----
// Iterative single-multiplier datapath for one weighted exponential term.
module rewds_term
    import rewds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  term_req_t req,
    output term_rsp_t rsp
);
    typedef enum logic [3:0] {
        T_IDLE, T_P, T_Y, T_F, T_H, T_HA, T_DW, T_AB, T_Q, T_SH
    } tstate_t;

    tstate_t            state_reg;
    logic signed [15:0] d_reg, a_reg, w_reg;
    logic signed [65:0] prod_reg;
    logic [7:0]         k_reg;
    logic [23:0]        f_reg;
    logic [31:0]        acc_reg;
    logic [2:0]         hcnt_reg;
    logic               neg_reg;
    logic [31:0]        mag_reg;
    logic               done_reg;
    logic signed [32:0] value_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] y;
    logic signed [31:0] dw;
    logic signed [8:0]  sft;
    logic [8:0]         rsh;
    logic [61:0]        mag;
    logic [31:0]        lim, lim_sh;
    logic [61:0]        t1, r62;
    logic [31:0]        r;
    logic signed [32:0] t;

    always_comb begin
        case (state_reg)
            T_P: begin
                mul_a = 33'(a_reg);
                mul_b = 33'(d_reg);
            end
            T_Y: begin
                mul_a = 33'(signed'(prod_reg[31:0]));
                mul_b = LOG2E_Q30;
            end
            T_H: begin
                mul_a = {1'b0, acc_reg};
                mul_b = {3'b0, f_reg, 6'b0};
            end
            T_DW: begin
                mul_a = 33'(d_reg);
                mul_b = 33'(w_reg);
            end
            T_Q: begin
                mul_a = {1'b0, mag_reg};
                mul_b = {1'b0, acc_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign y  = signed'(prod_reg[61:30]);
    assign dw = signed'(prod_reg[31:0]);

    always_comb begin
        sft    = signed'({k_reg[7], k_reg}) - 9'sd38;
        rsh    = 9'd0 - 9'(sft);
        mag    = prod_reg[61:0];
        lim    = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        lim_sh = lim >> sft[4:0];
        t1     = mag >> (rsh[5:0] - 6'd1);
        r62    = (t1 + 62'd1) >> 1;
        if (mag == '0) begin
            r = '0;
        end else if (!sft[8]) begin
            if (sft >= 9'sd32) begin
                r = lim;
            end else if (mag > {30'b0, lim_sh}) begin
                r = lim;
            end else begin
                r = 32'(mag << sft[4:0]);
            end
        end else if (rsh >= 9'd64) begin
            r = '0;
        end else if (r62 > {30'b0, lim}) begin
            r = lim;
        end else begin
            r = r62[31:0];
        end
        t = neg_reg ? -signed'({1'b0, r}) : signed'({1'b0, r});
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                T_IDLE: begin
                    if (req.start) begin
                        d_reg     <= req.descriptor;
                        a_reg     <= req.alpha;
                        w_reg     <= req.weight;
                        state_reg <= T_P;
                    end
                end
                T_P: state_reg <= T_Y;
                T_Y: state_reg <= T_F;
                T_F: begin
                    k_reg     <= y[31:24];
                    f_reg     <= y[23:0];
                    acc_reg   <= PC5;
                    hcnt_reg  <= '0;
                    state_reg <= T_H;
                end
                T_H: state_reg <= T_HA;
                T_HA: begin
                    acc_reg  <= horner_coef(hcnt_reg) + prod_reg[61:30];
                    hcnt_reg <= hcnt_reg + 3'd1;
                    state_reg <= (hcnt_reg == 3'd4) ? T_DW : T_H;
                end
                T_DW: state_reg <= T_AB;
                T_AB: begin
                    neg_reg   <= dw[31];
                    mag_reg   <= dw[31] ? 32'(-dw) : 32'(dw);
                    state_reg <= T_Q;
                end
                T_Q: state_reg <= T_SH;
                T_SH: begin
                    value_reg <= t;
                    done_reg  <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;
endmodule

// ----- tb/rewds_checker.sv -----
// Checker for the radial exponentially weighted descriptor sum unit: predicts and compares term sums.
`timescale 1ns / 1ps

module rewds_checker
    import rewds_pkg::*;
#(
    parameter int NUM_TERMS   = 8,
    parameter int NUM_SPECIES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          sums_pending
);

    typedef struct {
        logic [2:0]  term_index;
        logic [31:0] sum_value;
        logic        last;
    } term_sum_t;

    logic signed [15:0] alpha_coef [NUM_SPECIES*NUM_TERMS];
    logic signed [15:0] embed_weight [NUM_SPECIES*NUM_TERMS];
    longint             term_acc [NUM_TERMS];
    term_sum_t          expected_sums [$];

    // d * 2^(alpha*d*log2e) * w in Q16.16, rounded and saturated
    function automatic longint term_contribution(logic signed [15:0] d,
                                                 logic signed [15:0] a,
                                                 logic signed [15:0] w);
        longint      prod, y, k, dw, s, sh;
        logic [63:0] f, fq, acc, m, mag, lim, r;
        logic        neg;
        prod = longint'(a) * longint'(d);
        y    = (prod * 64'sd1549082005) >>> 30;
        k    = y >>> 24;
        f    = y - (k <<< 24);
        fq   = f << 6;
        acc  = 64'(PC5);
        acc  = 64'(PC4) + ((acc * fq) >> 30);
        acc  = 64'(PC3) + ((acc * fq) >> 30);
        acc  = 64'(PC2) + ((acc * fq) >> 30);
        acc  = 64'(PC1) + ((acc * fq) >> 30);
        m    = 64'(ONE_Q30) + ((acc * fq) >> 30);
        dw   = longint'(d) * longint'(w);
        neg  = dw < 0;
        mag  = 64'(neg ? -dw : dw) * m;
        s    = k - 38;
        lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag == 0)
            return 0;
        if (s >= 0) begin
            if (s >= 32 || mag > (lim >> s))
                r = lim;
            else
                r = mag << s;
        end else begin
            sh = -s;
            if (sh >= 64)
                r = 0;
            else
                r = (mag + (64'd1 << (sh - 1))) >> sh;
            if (r > lim)
                r = lim;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint saturate32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    always @(posedge aclk) begin
        logic [1:0]         op;
        logic [1:0]         sp;
        logic [2:0]         ai;
        logic signed [15:0] d;
        term_sum_t          exp_sum;
        if (!aresetn) begin
            foreach (alpha_coef[i]) begin
                alpha_coef[i]   = '0;
                embed_weight[i] = '0;
            end
            foreach (term_acc[i])
                term_acc[i] = 0;
            expected_sums.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected result: term_index %0d sum_value %h",
                           m_tdata[2:0], m_tdata[34:3]);
                    fail_count++;
                end else begin
                    exp_sum = expected_sums.pop_front();
                    if (m_tdata[2:0] !== exp_sum.term_index) begin
                        $error("term_index: expected %0d actual %0d",
                               exp_sum.term_index, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[34:3] !== exp_sum.sum_value) begin
                        $error("sum_value: expected %h actual %h",
                               exp_sum.sum_value, m_tdata[34:3]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_sum.last) begin
                        $error("last: expected %0d actual %0d", exp_sum.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                op = s_tdata[1:0];
                sp = s_tdata[3:2];
                ai = s_tdata[6:4];
                d  = s_tdata[54:39];
                case (op)
                    OP_WRITE: begin
                        if (sp < NUM_SPECIES && ai < NUM_TERMS) begin
                            alpha_coef[sp*NUM_TERMS+ai]   = s_tdata[22:7];
                            embed_weight[sp*NUM_TERMS+ai] = s_tdata[38:23];
                        end
                    end
                    OP_SAMPLE: begin
                        if (sp < NUM_SPECIES)
                            for (int i = 0; i < NUM_TERMS; i++)
                                term_acc[i] = saturate32(term_acc[i] + term_contribution(
                                    d, alpha_coef[sp*NUM_TERMS+i],
                                    embed_weight[sp*NUM_TERMS+i]));
                    end
                    OP_EMIT: begin
                        for (int i = 0; i < NUM_TERMS; i++) begin
                            exp_sum.term_index = 3'(i);
                            exp_sum.sum_value  = 32'(term_acc[i]);
                            exp_sum.last       = (i == NUM_TERMS - 1);
                            expected_sums.push_back(exp_sum);
                            term_acc[i] = 0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        sums_pending = expected_sums.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import rewds_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1500000;
    localparam int         ITEM_TARGET = 480;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          sums_pending;
    int          cycle_count = 0;
    int          items_sent = 0;

    radial_exp_weighted_descriptor_sum_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    rewds_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .sums_pending(sums_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // offer one request, hold until accepted
    task automatic send_request(logic [1:0] op, logic [1:0] sp, logic [2:0] ai,
                                logic [15:0] av, logic [15:0] wv, logic [15:0] d);
        int gap;
        gap = idle_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {1'b0, d, wv, av, ai, sp, op};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    function automatic logic [15:0] random_alpha();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // drop m_tready at random; hold it off for a long stretch once
    initial begin
        int len;
        wait (aresetn);
        repeat (1500) begin
            @(negedge aclk);
            m_tready = $urandom_range(0, 3) != 0;
        end
        @(negedge aclk);
        m_tready = 1'b0;
        repeat (4000) @(negedge aclk);
        forever begin
            if ($urandom_range(0, 1)) begin
                m_tready = 1'b1;
                len = $urandom_range(1, 20);
            end else begin
                m_tready = 1'b0;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
            end
            repeat (len) @(negedge aclk);
        end
    end

    initial begin
        int nw, ns;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(OP_EMIT, 2'd0, 3'd0, 16'h0, 16'h0, 16'h0);
        send_request(OP_WRITE, 2'd0, 3'd0, 16'h7FFF, 16'h7FFF, 16'h0);
        send_request(OP_WRITE, 2'd3, 3'd7, 16'h8000, 16'h8000, 16'hFFFF);
        send_request(OP_WRITE, 2'd1, 3'd3, 16'h0000, 16'h1000, 16'h0);
        send_request(OP_WRITE, 2'd2, 3'd5, 16'hF000, 16'h7FFF, 16'h0);
        send_request(OP_WRITE, 2'd2, 3'd6, 16'hFFFF, 16'hFFFF, 16'h0);
        send_request(OP_SAMPLE, 2'd0, 3'd7, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_request(OP_SAMPLE, 2'd0, 3'd0, 16'h0, 16'h0, 16'h8000);
        send_request(OP_SAMPLE, 2'd3, 3'd0, 16'h0, 16'h0, 16'h8000);
        send_request(OP_SAMPLE, 2'd3, 3'd0, 16'h0, 16'h0, 16'h7FFF);
        send_request(OP_EMIT, 2'd3, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_EMIT, 2'd0, 3'd0, 16'h0, 16'h0, 16'h0);
        send_request(OP_UNUSED, 2'd1, 3'd2, 16'h1234, 16'h5678, 16'h1000);
        send_request(OP_SAMPLE, 2'd1, 3'd0, 16'h0, 16'h0, 16'h1000);
        send_request(OP_SAMPLE, 2'd2, 3'd0, 16'h0, 16'h0, 16'h8000);
        send_request(OP_SAMPLE, 2'd2, 3'd0, 16'h0, 16'h0, 16'h0);
        send_request(OP_SAMPLE, 2'd0, 3'd0, 16'h0, 16'h0, 16'h7FFF);
        send_request(OP_SAMPLE, 2'd0, 3'd0, 16'h0, 16'h0, 16'h7FFF);
        send_request(OP_EMIT, 2'd1, 3'd1, 16'h0, 16'h0, 16'h0);

        while (items_sent < ITEM_TARGET) begin
            nw = $urandom_range(0, 3);
            ns = $urandom_range(0, 10);
            repeat (nw)
                send_request(OP_WRITE, 2'($urandom), 3'($urandom), random_alpha(),
                             16'($urandom), 16'($urandom));
            repeat (ns) begin
                if ($urandom_range(0, 19) == 0)
                    send_request(OP_UNUSED, 2'($urandom), 3'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
                send_request(OP_SAMPLE, 2'($urandom), 3'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 9) != 0)
                send_request(OP_EMIT, 2'($urandom), 3'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
        end
        send_request(OP_EMIT, 2'd0, 3'd0, 16'h0, 16'h0, 16'h0);
        @(negedge aclk);
        s_tvalid = 1'b0;

        while (sums_pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rewds_pkg.sv
hdl/rewds_ram.sv
hdl/rewds_term.sv
hdl/radial_exp_weighted_descriptor_sum_unit.sv
tb/rewds_checker.sv
tb/testbench.sv
